FILE: src/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 32;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TEXT   = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] character;
	} item_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} res_t;

endpackage

FILE: src/wgm_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface wgm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/wgm_nfa.sv
// Pattern store and bit-vector NFA with star closure.
module wgm_nfa #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  wgm_pkg::item_t item,
	output wgm_pkg::res_t  res
);
	import wgm_pkg::*;

	localparam int VW   = MAX_PATTERN + 1;
	localparam int LVLS = (VW > 1) ? $clog2(VW) : 1;

	logic [7:0]             store_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] used_q;    // thermometer of written entries
	logic [VW-1:0]          endpos_q;  // one-hot at the pattern length
	logic [VW-1:0]          active_q;  // closed position vector
	logic [VW-1:0]          lead_q;    // closed restart vector
	logic                   ovf_q;

	logic [MAX_PATTERN-1:0] star;
	logic [MAX_PATTERN-1:0] hit;
	logic [VW-1:0]          step_v;
	logic [VW-1:0]          closed_v;
	logic [VW-1:0]          lead_app;
	logic                   full;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			star[i] = used_q[i] && (store_q[i] == STAR_BYTE);
			hit[i]  = used_q[i] && (store_q[i] != STAR_BYTE) &&
				((store_q[i] == ANY_BYTE) || (store_q[i] == item.character));
		end
	end

	assign step_v = {1'b0, active_q[MAX_PATTERN-1:0] & star}
		| {active_q[MAX_PATTERN-1:0] & hit, 1'b0};

	// Star closure as a parallel prefix: a bit runs forward across a run of stars.
	always_comb begin
		logic [VW-1:0] g;
		logic [VW-1:0] p;
		g = step_v;
		p = {star, 1'b0};
		for (int l = 0; l < LVLS; l++) begin
			g = g | (p & (g << (1 << l)));
			p = p & (p << (1 << l));
		end
		closed_v = g;
	end

	assign full = used_q[MAX_PATTERN-1];
	// Restart vector grows only while the pattern so far is all stars.
	assign lead_app = lead_q
		| (((lead_q & endpos_q) << 1) & {VW{item.character == STAR_BYTE}});

	always_ff @(posedge clk) begin
		if (fire && item.kind == KIND_APPEND) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (endpos_q[i])
					store_q[i] <= item.character;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			endpos_q <= VW'(1);
			active_q <= VW'(1);
			lead_q   <= VW'(1);
			ovf_q    <= 1'b0;
		end else if (fire) begin
			unique case (item.kind)
				KIND_CLEAR: begin
					used_q   <= '0;
					endpos_q <= VW'(1);
					active_q <= VW'(1);
					lead_q   <= VW'(1);
					ovf_q    <= 1'b0;
				end
				KIND_APPEND: begin
					if (full) begin
						ovf_q    <= 1'b1;
						active_q <= lead_q;
					end else begin
						used_q   <= used_q | endpos_q[MAX_PATTERN-1:0];
						endpos_q <= endpos_q << 1;
						lead_q   <= lead_app;
						active_q <= lead_app;
					end
				end
				KIND_TEXT: active_q <= closed_v;
				KIND_END:  active_q <= lead_q;
				default:   active_q <= active_q;
			endcase
		end
	end

	assign res.matched  = (|(active_q & endpos_q)) && !ovf_q;
	assign res.overflow = ovf_q;

endmodule

FILE: src/wildcard_glob_matcher.sv
// Glob matcher ('?' one byte, '*' any run) over a streamed text. Items are
// taken one per cycle: clear, append a pattern byte, text byte, or end of text;
// only an end item returns a result (matched, overflow), via input and result
// registers. The input register frees every cycle while the result register
// can take a new result, so a stalled result side stalls the input only once an
// end item waits behind a held result; items behind that end item wait as well.
// Pattern holds up to MAX_PATTERN bytes; a longer pattern sets overflow.
module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input logic          clk,
	input logic          arst_n,
	wgm_stream_if.sink   item,
	wgm_stream_if.source result
);
	import wgm_pkg::*;

	logic  s1_valid_q;
	item_t item_s1;
	logic  out_valid_q;
	res_t  out_data_q;
	res_t  nfa_res;
	logic  out_free;
	logic  s1_fire;
	logic  end_fire;

	assign out_free   = !out_valid_q || result.ready;
	assign s1_fire    = s1_valid_q && ((item_s1.kind != KIND_END) || out_free);
	assign end_fire   = s1_fire && (item_s1.kind == KIND_END);
	assign item.ready = !s1_valid_q || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item.ready) begin
			s1_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			item_s1 <= item.data;
	end

	wgm_nfa #(.MAX_PATTERN(MAX_PATTERN)) u_nfa (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_fire),
		.item   (item_s1),
		.res    (nfa_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire)
			out_data_q <= nfa_res;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		end_fire |=> out_valid_q)
		else $error("end transfer produced no result");

	a_taken_result_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.ready && !end_fire) |=> !out_valid_q)
		else $error("result repeated after transfer");

	a_match_excludes_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.matched) |-> !out_data_q.overflow)
		else $error("match reported with overflow");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (s1_valid_q && item_s1.kind == KIND_END && out_valid_q))
		else $error("input stalled without a pending end item");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for wildcard_glob_matcher: glob patterns, streamed text, overflow.
`timescale 1ns / 100ps

module testbench;
	import wgm_pkg::*;

	localparam int PAT_MAX  = MAX_PATTERN_DEF;
	localparam int VQ_DEPTH = 64;
	localparam int PAT_BUF  = 64;
	localparam int TXT_BUF  = 128;
	localparam logic [7:0] CH_A = "a";
	localparam logic [7:0] CH_B = "b";
	localparam logic [7:0] CH_C = "c";

	logic clk;
	logic arst_n;

	wgm_stream_if #(.T(item_t)) item_bus ();
	wgm_stream_if #(.T(res_t))  result_bus ();

	wildcard_glob_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	// glob predictor state
	logic [7:0]       pat_bytes [PAT_MAX];
	int               pat_len;
	logic [PAT_MAX:0] live_pos;
	logic             pat_over;

	// expected results, ring buffer
	res_t verdict_mem [VQ_DEPTH];
	int   vq_wr;
	int   vq_rd;
	int   pending;
	int   mismatch_count;
	int   sent_count;
	int   gap_pct;
	int   stall_pct;
	int   hold_left;

	always #4 clk = ~clk;

	function automatic void close_stars();
		for (int i = 0; i < pat_len; i++)
			if (live_pos[i] && pat_bytes[i] == STAR_BYTE)
				live_pos[i + 1] = 1'b1;
	endfunction

	function automatic void restart_text();
		live_pos    = '0;
		live_pos[0] = 1'b1;
	endfunction

	function automatic void consume_byte(logic [7:0] c);
		logic [PAT_MAX:0] nxt;
		nxt = '0;
		close_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live_pos[i]) begin
				if (pat_bytes[i] == STAR_BYTE)
					nxt[i] = 1'b1;
				else if (pat_bytes[i] == ANY_BYTE || pat_bytes[i] == c)
					nxt[i + 1] = 1'b1;
			end
		end
		live_pos = nxt;
		close_stars();
	endfunction

	function automatic void glob_apply(item_t it);
		res_t want;
		case (it.kind)
			KIND_CLEAR: begin
				pat_len  = 0;
				pat_over = 1'b0;
				restart_text();
			end
			KIND_APPEND: begin
				if (pat_len < PAT_MAX) begin
					pat_bytes[pat_len] = it.character;
					pat_len++;
				end else begin
					pat_over = 1'b1;
				end
				restart_text();
			end
			KIND_TEXT: consume_byte(it.character);
			default: begin
				close_stars();
				want.matched  = live_pos[pat_len] && !pat_over;
				want.overflow = pat_over;
				verdict_mem[vq_wr % VQ_DEPTH] = want;
				vq_wr++;
				pending++;
				restart_text();
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		mismatch_count++;
	endtask

	// one transfer on the item channel; valid stays high on return
	task automatic send_item(input kind_t k, input logic [7:0] ch);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.data  <= '{kind: k, character: ch};
		do @(posedge clk); while (!item_bus.ready);
		glob_apply(item_bus.data);
		sent_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		wait (pending == 0);
	endtask

	// result side: long hold-off has priority over random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_bus.ready <= 1'b0;
			hold_left--;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending == 0) begin
				report_mismatch($sformatf("unexpected result m=%0b o=%0b",
					result_bus.data.matched, result_bus.data.overflow));
			end else begin
				want = verdict_mem[vq_rd % VQ_DEPTH];
				vq_rd++;
				pending--;
				if (result_bus.data.matched !== want.matched)
					report_mismatch($sformatf("matched got %0b want %0b",
						result_bus.data.matched, want.matched));
				if (result_bus.data.overflow !== want.overflow)
					report_mismatch($sformatf("overflow got %0b want %0b",
						result_bus.data.overflow, want.overflow));
			end
		end
	end

	function automatic logic [7:0] pick_pattern_byte();
		int r;
		r = $urandom_range(9);
		if (r < 3) return STAR_BYTE;
		if (r < 5) return ANY_BYTE;
		if (r < 7) return ($urandom_range(1) != 0) ? CH_A : CH_B;
		if (r == 7) return CH_C;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(3);
		if (r == 0) return CH_A;
		if (r == 1) return CH_B;
		if (r == 2) return CH_C;
		return 8'($urandom_range(255));
	endfunction

	// clear, load a pattern, then stream texts that mostly follow its shape
	task automatic run_glob_set(input int n_texts);
		logic [7:0] pat_b [PAT_BUF];
		logic [7:0] txt_b [TXT_BUF];
		int         len;
		int         n_txt;
		len = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 7);
		send_item(KIND_CLEAR, 8'($urandom_range(255)));
		for (int i = 0; i < len; i++) begin
			pat_b[i] = pick_pattern_byte();
			send_item(KIND_APPEND, pat_b[i]);
		end
		for (int t = 0; t < n_texts; t++) begin
			n_txt = 0;
			if ($urandom_range(9) < 6) begin
				for (int i = 0; i < len; i++) begin
					if (pat_b[i] == STAR_BYTE) begin
						repeat ($urandom_range(3)) begin
							txt_b[n_txt] = pick_text_byte();
							n_txt++;
						end
					end else if (pat_b[i] == ANY_BYTE) begin
						txt_b[n_txt] = 8'($urandom_range(255));
						n_txt++;
					end else begin
						txt_b[n_txt] = pat_b[i];
						n_txt++;
					end
				end
				if ($urandom_range(3) == 0) begin
					if (n_txt > 0 && $urandom_range(1) != 0) begin
						txt_b[$urandom_range(n_txt - 1)] = pick_text_byte();
					end else if (n_txt > 0) begin
						n_txt--;
					end else begin
						txt_b[0] = pick_text_byte();
						n_txt    = 1;
					end
				end
			end else begin
				repeat ($urandom_range(8)) begin
					txt_b[n_txt] = pick_text_byte();
					n_txt++;
				end
			end
			for (int i = 0; i < n_txt; i++) send_item(KIND_TEXT, txt_b[i]);
			send_item(KIND_END, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_directed();
		send_item(KIND_END, 8'h00);      // empty text before any pattern
		send_item(KIND_TEXT, 8'hFF);
		send_item(KIND_END, 8'hFF);      // empty pattern vs one byte
		send_item(KIND_CLEAR, 8'hFF);
		send_item(KIND_APPEND, STAR_BYTE);
		send_item(KIND_END, 8'h00);      // star on empty text
		send_item(KIND_TEXT, 8'hFF);
		send_item(KIND_TEXT, 8'h00);
		send_item(KIND_END, 8'h00);
		send_item(KIND_CLEAR, 8'h00);
		send_item(KIND_APPEND, ANY_BYTE);
		send_item(KIND_APPEND, 8'h00);
		send_item(KIND_TEXT, 8'hFF);
		send_item(KIND_TEXT, 8'h00);
		send_item(KIND_END, 8'h00);
		// back-to-back stars act as one
		send_item(KIND_APPEND, STAR_BYTE);
		send_item(KIND_APPEND, STAR_BYTE);
		send_item(KIND_END, 8'h00);
		send_item(KIND_TEXT, 8'h80);
		send_item(KIND_TEXT, 8'h00);
		send_item(KIND_TEXT, 8'h7F);
		send_item(KIND_END, 8'h00);
		drain_results();
	endtask

	task automatic test_full_pattern();
		send_item(KIND_CLEAR, 8'h00);
		send_item(KIND_APPEND, STAR_BYTE);
		repeat (PAT_MAX - 1) send_item(KIND_APPEND, ANY_BYTE);
		repeat (PAT_MAX - 1) send_item(KIND_TEXT, 8'($urandom_range(255)));
		send_item(KIND_END, 8'h00);      // store exactly full, matches
		repeat (PAT_MAX - 3) send_item(KIND_TEXT, CH_A);
		send_item(KIND_END, 8'h00);      // too short
		send_item(KIND_APPEND, CH_A);    // one past the store
		repeat (PAT_MAX + 4) send_item(KIND_TEXT, CH_B);
		send_item(KIND_END, 8'h00);
		send_item(KIND_END, 8'h00);
		send_item(KIND_APPEND, CH_B);    // flag is sticky
		send_item(KIND_END, 8'h00);
		send_item(KIND_CLEAR, 8'h00);
		send_item(KIND_END, 8'h00);
		drain_results();
	endtask

	task automatic test_result_holdoff();
		gap_pct = 0;
		send_item(KIND_CLEAR, 8'h00);
		send_item(KIND_APPEND, STAR_BYTE);
		send_item(KIND_APPEND, CH_A);
		hold_left = 150;
		// ends pile up behind the stalled result side
		repeat (12) begin
			send_item(KIND_TEXT, ($urandom_range(1) != 0) ? CH_A : CH_B);
			send_item(KIND_END, 8'h00);
		end
		drain_results();
	endtask

	task automatic test_random_globs();
		int target;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 57; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 57; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase
			target = sent_count + 200;
			while (sent_count < target)
				run_glob_set($urandom_range(1, 5));
			drain_results();
		end
	endtask

	task automatic test_noise();
		gap_pct   = 22;
		stall_pct = 22;
		repeat (150)
			send_item(kind_t'($urandom_range(3)), 8'($urandom_range(255)));
		drain_results();
	endtask

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		item_bus.valid   = 1'b0;
		item_bus.data    = '0;
		result_bus.ready = 1'b0;
		pat_len          = 0;
		pat_over         = 1'b0;
		live_pos         = '0;
		live_pos[0]      = 1'b1;
		vq_wr            = 0;
		vq_rd            = 0;
		pending          = 0;
		mismatch_count   = 0;
		sent_count       = 0;
		gap_pct          = 0;
		stall_pct        = 0;
		hold_left        = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_pattern();
		test_result_holdoff();
		test_random_globs();
		test_noise();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
src/wgm_pkg.sv
src/wgm_stream_if.sv
src/wgm_nfa.sv
src/wildcard_glob_matcher.sv
tb/testbench.sv
